// ----- hw/rtl/vfcp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vfcp_pkg;

    localparam logic [2:0] EV_COMMENT   = 3'd0;
    localparam logic [2:0] EV_PREAMBLE  = 3'd1;
    localparam logic [2:0] EV_CHAR      = 3'd2;
    localparam logic [2:0] EV_PACKET    = 3'd3;
    localparam logic [2:0] EV_FONT      = 3'd4;
    localparam logic [2:0] EV_NAME      = 3'd5;
    localparam logic [2:0] EV_POSTAMBLE = 3'd6;
    localparam logic [2:0] EV_ERROR     = 3'd7;

    localparam logic [31:0] ERR_BAD_OPCODE = 32'd0;
    localparam logic [31:0] ERR_BAD_ID     = 32'd1;

    localparam logic [7:0] OP_SHORT_CHAR_MAX = 8'd241;
    localparam logic [7:0] OP_LONG_CHAR      = 8'd242;
    localparam logic [7:0] OP_FONT_DEF_MAX   = 8'd246;
    localparam logic [7:0] OP_PREAMBLE       = 8'd247;
    localparam logic [7:0] OP_POSTAMBLE      = 8'd248;
    localparam logic [7:0] PREAMBLE_ID       = 8'd202;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [31:0] code_or_number;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic [31:0] third_value;
        logic [7:0]  byte_value;
        logic        last_in_run;
    } vfcp_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/virtual_font_command_parser_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Virtual font command parser.
// Input stream: one file byte per beat on s_axis_tdata.
// Output stream: at most one event per input byte. tuser carries the event kind,
// tlast marks the final byte of a comment, packet or font name run, and tdata
// carries code_or_number, first_value, second_value, third_value and byte_value.
// Config: cfg_we/cfg_wdata write fonts_only_mode; write only while the block is idle.
// Path: a byte is accepted into the input register, then decoded into the output
// register, where its event becomes valid.
// Throughput: one byte per cycle while the output is not stalled by m_axis_tready.
// Reset clears the parser to wait for an opcode and clears both stage valid flags;
// fonts_only_mode resets to 0. After a postamble, an error or a character opcode
// in fonts_only_mode, the parser halts and drops every byte until reset.
// When the receiver stalls, the output register holds its beat, one more byte
// waits in the input register, and s_axis_tready drops until the event drains.

module virtual_font_command_parser_top
    import vfcp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] file_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [135:0]      m_axis_tdata,   // [31:0] code_or_number, [63:32] first_value,
                                              // [95:64] second_value, [127:96] third_value,
                                              // [135:128] byte_value
    output logic [2:0]        m_axis_tuser,   // [2:0] event_kind
    output logic              m_axis_tlast,   // last_in_run
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg, in_byte_next;
    logic         fonts_only_mode_reg, fonts_only_mode_next;
    logic         can_load;
    logic         step;
    logic         result_valid;
    vfcp_result_t result;
    logic         halted;

    assign step          = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || can_load;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_axis_tdata;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        fonts_only_mode_next = cfg_we ? cfg_wdata : fonts_only_mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            fonts_only_mode_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg        <= in_valid_next;
            fonts_only_mode_reg <= fonts_only_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
    end

    vfcp_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .file_byte       (in_byte_reg),
        .fonts_only_mode (fonts_only_mode_reg),
        .result_valid    (result_valid),
        .result          (result),
        .halted          (halted)
    );

    vfcp_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (result_valid),
        .result        (result),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_halt_after_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.event_kind == EV_ERROR || result.event_kind == EV_POSTAMBLE)
        |=> halted)
        else $error("parser not halted after error or postamble");

    a_silent_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
        halted |-> !result_valid)
        else $error("event produced while halted");

    a_last_only_on_runs: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast
        |-> (m_axis_tuser == EV_COMMENT || m_axis_tuser == EV_PACKET
             || m_axis_tuser == EV_NAME))
        else $error("tlast on an event that is not a byte run");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ----- hw/rtl/vfcp_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vfcp_parser
    import vfcp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   file_byte,
    input  wire logic         fonts_only_mode,
    output logic              result_valid,
    output vfcp_result_t      result,
    output logic              halted
);

    localparam logic [4:0] PH_OP      = 5'd0;
    localparam logic [4:0] PH_PRE_ID  = 5'd1;
    localparam logic [4:0] PH_PRE_LEN = 5'd2;
    localparam logic [4:0] PH_PRE_CMT = 5'd3;
    localparam logic [4:0] PH_PRE_CS  = 5'd4;
    localparam logic [4:0] PH_PRE_DS  = 5'd5;
    localparam logic [4:0] PH_SC_CC   = 5'd6;
    localparam logic [4:0] PH_SC_W    = 5'd7;
    localparam logic [4:0] PH_LC_PL   = 5'd8;
    localparam logic [4:0] PH_LC_CC   = 5'd9;
    localparam logic [4:0] PH_LC_W    = 5'd10;
    localparam logic [4:0] PH_PKT     = 5'd11;
    localparam logic [4:0] PH_FD_NUM  = 5'd12;
    localparam logic [4:0] PH_FD_CS   = 5'd13;
    localparam logic [4:0] PH_FD_SS   = 5'd14;
    localparam logic [4:0] PH_FD_DS   = 5'd15;
    localparam logic [4:0] PH_FD_PL   = 5'd16;
    localparam logic [4:0] PH_FD_NL   = 5'd17;
    localparam logic [4:0] PH_FD_PATH = 5'd18;
    localparam logic [4:0] PH_FD_NAME = 5'd19;

    logic [4:0]  phase_reg, phase_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [2:0]  fbl_reg, fbl_next;
    logic [31:0] run_reg, run_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] cs_reg, cs_next;
    logic [31:0] ss_reg, ss_next;
    logic [7:0]  pl_reg, pl_next;
    logic [7:0]  nl_reg, nl_next;
    logic        id_ok_reg, id_ok_next;
    logic        halted_reg, halted_next;

    logic [31:0] acc_shift;
    logic [2:0]  fbl_dec;
    logic        field_done;
    logic [31:0] run_dec;
    logic [7:0]  pl_dec;
    logic [7:0]  nl_dec;

    assign acc_shift  = {acc_reg[23:0], file_byte};
    assign fbl_dec    = (fbl_reg != 3'd0) ? fbl_reg - 3'd1 : 3'd0;
    assign field_done = (fbl_dec == 3'd0);
    assign run_dec    = (run_reg != 32'd0) ? run_reg - 32'd1 : 32'd0;
    assign pl_dec     = (pl_reg != 8'd0) ? pl_reg - 8'd1 : 8'd0;
    assign nl_dec     = (nl_reg != 8'd0) ? nl_reg - 8'd1 : 8'd0;

    always_comb
    begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        fbl_next     = fbl_reg;
        run_next     = run_reg;
        acc_next     = acc_reg;
        num_next     = num_reg;
        cs_next      = cs_reg;
        ss_next      = ss_reg;
        pl_next      = pl_reg;
        nl_next      = nl_reg;
        id_ok_next   = id_ok_reg;
        halted_next  = halted_reg;
        result_valid = 1'b0;
        result       = '0;

        if (step && !halted_reg)
        begin
            case (phase_reg)
                PH_OP:
                begin
                    opcode_next = file_byte;
                    if (file_byte <= OP_LONG_CHAR)
                    begin
                        if (fonts_only_mode)
                        begin
                            halted_next = 1'b1;
                        end
                        else if (file_byte <= OP_SHORT_CHAR_MAX)
                        begin
                            phase_next = PH_SC_CC;
                        end
                        else
                        begin
                            phase_next = PH_LC_PL;
                            fbl_next   = 3'd4;
                            acc_next   = '0;
                        end
                    end
                    else if (file_byte <= OP_FONT_DEF_MAX)
                    begin
                        phase_next = PH_FD_NUM;
                        fbl_next   = 3'(file_byte - OP_LONG_CHAR);
                        acc_next   = '0;
                    end
                    else if (file_byte == OP_PREAMBLE)
                    begin
                        phase_next = PH_PRE_ID;
                    end
                    else
                    begin
                        halted_next  = 1'b1;
                        result_valid = 1'b1;
                        if (file_byte == OP_POSTAMBLE)
                        begin
                            result.event_kind = EV_POSTAMBLE;
                        end
                        else
                        begin
                            result.event_kind     = EV_ERROR;
                            result.code_or_number = ERR_BAD_OPCODE;
                        end
                    end
                end

                PH_PRE_ID:
                begin
                    id_ok_next = (file_byte == PREAMBLE_ID);
                    phase_next = PH_PRE_LEN;
                end

                PH_PRE_LEN:
                begin
                    run_next = {24'd0, file_byte};
                    if (file_byte == 8'd0)
                    begin
                        phase_next = PH_PRE_CS;
                        fbl_next   = 3'd4;
                        acc_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_PRE_CMT;
                    end
                end

                PH_PRE_CMT:
                begin
                    run_next = run_dec;
                    if (run_dec == 32'd0)
                    begin
                        phase_next = PH_PRE_CS;
                        fbl_next   = 3'd4;
                        acc_next   = '0;
                    end
                    result_valid       = 1'b1;
                    result.event_kind  = EV_COMMENT;
                    result.byte_value  = file_byte;
                    result.last_in_run = (run_dec == 32'd0);
                end

                PH_PRE_CS:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        cs_next    = acc_shift;
                        phase_next = PH_PRE_DS;
                        fbl_next   = 3'd4;
                        acc_next   = '0;
                    end
                end

                PH_PRE_DS:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        phase_next   = PH_OP;
                        result_valid = 1'b1;
                        if (!id_ok_reg)
                        begin
                            halted_next           = 1'b1;
                            result.event_kind     = EV_ERROR;
                            result.code_or_number = ERR_BAD_ID;
                        end
                        else
                        begin
                            result.event_kind   = EV_PREAMBLE;
                            result.first_value  = cs_reg;
                            result.second_value = acc_shift;
                        end
                    end
                end

                PH_SC_CC:
                begin
                    num_next   = {24'd0, file_byte};
                    phase_next = PH_SC_W;
                    fbl_next   = 3'd3;
                    acc_next   = '0;
                end

                PH_SC_W:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        run_next   = {24'd0, opcode_reg};
                        phase_next = (opcode_reg != 8'd0) ? PH_PKT : PH_OP;
                        result_valid          = 1'b1;
                        result.event_kind     = EV_CHAR;
                        result.code_or_number = num_reg;
                        result.first_value    = {24'd0, opcode_reg};
                        result.second_value   = acc_shift;
                    end
                end

                PH_LC_PL:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        run_next   = acc_shift;
                        phase_next = PH_LC_CC;
                        fbl_next   = 3'd4;
                        acc_next   = '0;
                    end
                end

                PH_LC_CC:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        num_next   = acc_shift;
                        phase_next = PH_LC_W;
                        fbl_next   = 3'd4;
                        acc_next   = '0;
                    end
                end

                PH_LC_W:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        phase_next = (run_reg != 32'd0) ? PH_PKT : PH_OP;
                        result_valid          = 1'b1;
                        result.event_kind     = EV_CHAR;
                        result.code_or_number = num_reg;
                        result.first_value    = run_reg;
                        result.second_value   = acc_shift;
                    end
                end

                PH_PKT:
                begin
                    run_next = run_dec;
                    if (run_dec == 32'd0)
                    begin
                        phase_next = PH_OP;
                    end
                    result_valid       = 1'b1;
                    result.event_kind  = EV_PACKET;
                    result.byte_value  = file_byte;
                    result.last_in_run = (run_dec == 32'd0);
                end

                PH_FD_NUM:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        num_next   = acc_shift;
                        phase_next = PH_FD_CS;
                        fbl_next   = 3'd4;
                        acc_next   = '0;
                    end
                end

                PH_FD_CS:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        cs_next    = acc_shift;
                        phase_next = PH_FD_SS;
                        fbl_next   = 3'd4;
                        acc_next   = '0;
                    end
                end

                PH_FD_SS:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        ss_next    = acc_shift;
                        phase_next = PH_FD_DS;
                        fbl_next   = 3'd4;
                        acc_next   = '0;
                    end
                end

                PH_FD_DS:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        phase_next = PH_FD_PL;
                    end
                end

                PH_FD_PL:
                begin
                    pl_next    = file_byte;
                    phase_next = PH_FD_NL;
                end

                PH_FD_NL:
                begin
                    nl_next = file_byte;
                    if (pl_reg != 8'd0)
                    begin
                        phase_next = PH_FD_PATH;
                    end
                    else if (file_byte != 8'd0)
                    begin
                        phase_next = PH_FD_NAME;
                    end
                    else
                    begin
                        phase_next = PH_OP;
                    end
                    result_valid          = 1'b1;
                    result.event_kind     = EV_FONT;
                    result.code_or_number = num_reg;
                    result.first_value    = cs_reg;
                    result.second_value   = ss_reg;
                    result.third_value    = acc_reg;
                end

                PH_FD_PATH:
                begin
                    pl_next = pl_dec;
                    if (pl_dec == 8'd0)
                    begin
                        phase_next = (nl_reg != 8'd0) ? PH_FD_NAME : PH_OP;
                    end
                end

                PH_FD_NAME:
                begin
                    nl_next = nl_dec;
                    if (nl_dec == 8'd0)
                    begin
                        phase_next = PH_OP;
                    end
                    result_valid       = 1'b1;
                    result.event_kind  = EV_NAME;
                    result.byte_value  = file_byte;
                    result.last_in_run = (nl_dec == 8'd0);
                end

                default:
                begin
                    phase_next = PH_OP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OP;
            opcode_reg <= '0;
            fbl_reg    <= '0;
            run_reg    <= '0;
            acc_reg    <= '0;
            num_reg    <= '0;
            cs_reg     <= '0;
            ss_reg     <= '0;
            pl_reg     <= '0;
            nl_reg     <= '0;
            id_ok_reg  <= 1'b0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            fbl_reg    <= fbl_next;
            run_reg    <= run_next;
            acc_reg    <= acc_next;
            num_reg    <= num_next;
            cs_reg     <= cs_next;
            ss_reg     <= ss_next;
            pl_reg     <= pl_next;
            nl_reg     <= nl_next;
            id_ok_reg  <= id_ok_next;
            halted_reg <= halted_next;
        end
    end

    assign halted = halted_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/vfcp_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vfcp_out_stage
    import vfcp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire vfcp_result_t  result,
    output logic               can_load,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [135:0]       m_axis_tdata,
    output logic [2:0]         m_axis_tuser,
    output logic               m_axis_tlast
);

    logic         valid_reg, valid_next;
    vfcp_result_t data_reg, data_next;

    assign can_load = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = result;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {data_reg.byte_value, data_reg.third_value, data_reg.second_value,
                            data_reg.first_value, data_reg.code_or_number};
    assign m_axis_tuser  = data_reg.event_kind;
    assign m_axis_tlast  = data_reg.last_in_run;

endmodule

`default_nettype wire
